[rtl/core/pbrq_pkg.sv]
// ----------------------------------------------------------------------------
// pbrq_pkg
// Shared types, codes and helpers for the priority bitmap ready queue.
// ----------------------------------------------------------------------------
`default_nettype none

package pbrq_pkg;

  // Field widths fixed by the request and response formats
  localparam int NUM_LEVELS          = 16;
  localparam int LEVEL_BITS          = 4;
  localparam int TOP_BITS            = 5;
  localparam int TASK_ID_BITS        = 6;
  localparam int MODE_BITS           = 2;
  localparam int STATUS_BITS         = 2;
  localparam int DEF_SLOTS_PER_LEVEL = 8;

  // Top level value when no level holds a task
  localparam logic [TOP_BITS-1:0] LEVEL_NONE = TOP_BITS'(NUM_LEVELS);

  // Request modes
  localparam logic [MODE_BITS-1:0] MODE_TAIL = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_HEAD = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_DEL  = 2'd2;

  // Response status codes
  localparam logic [STATUS_BITS-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STAT_EMPTY = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic exec;     // update level FIFO, bitmap and top level
    logic load;     // read head task of top level into the response
  } pbrq_cmd_t;

  // Lowest set bit of the ready bitmap, LEVEL_NONE if empty
  function automatic logic [TOP_BITS-1:0] first_ready(input logic [NUM_LEVELS-1:0] bm);
    logic [TOP_BITS-1:0] r;
    r = LEVEL_NONE;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (bm[i]) r = TOP_BITS'(i);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/pbrq_ctrl.sv]
// ----------------------------------------------------------------------------
// pbrq_ctrl
// Sequencer: takes a request, runs the update and read steps, and owns the
// response valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module pbrq_ctrl
  import pbrq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output pbrq_cmd_t      cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       slot_free;

  // response slot can take new data when empty or being drained
  assign slot_free = !out_valid || out_ready;

  // next state and commands
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        if (slot_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/pbrq_dpath.sv]
// ----------------------------------------------------------------------------
// pbrq_dpath
// Per-level ring FIFOs (head index, count, slot memory), ready bitmap, top
// level register and response registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pbrq_dpath
  import pbrq_pkg::*;
#(
  parameter int SLOTS_PER_LEVEL = DEF_SLOTS_PER_LEVEL
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire pbrq_cmd_t                cmd,
  input  wire logic [MODE_BITS-1:0]     mode,
  input  wire logic [LEVEL_BITS-1:0]    level,
  input  wire logic [TASK_ID_BITS-1:0]  task_id,
  output logic      [TOP_BITS-1:0]      top_level,
  output logic      [TASK_ID_BITS-1:0]  top_task,
  output logic      [STATUS_BITS-1:0]   status
);

  localparam int IW    = (SLOTS_PER_LEVEL > 1) ? $clog2(SLOTS_PER_LEVEL) : 1;
  localparam int CW    = $clog2(SLOTS_PER_LEVEL + 1);
  localparam int SW    = ((IW > CW) ? IW : CW) + 1;
  localparam int AW    = LEVEL_BITS + IW;
  localparam int DEPTH = NUM_LEVELS * (1 << IW);

  localparam logic [IW-1:0] IDX_LAST = IW'(SLOTS_PER_LEVEL - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(SLOTS_PER_LEVEL);
  localparam logic [SW-1:0] SUM_WRAP = SW'(SLOTS_PER_LEVEL);

  // latched request
  logic [MODE_BITS-1:0]    req_mode;
  logic [LEVEL_BITS-1:0]   req_level;
  logic [TASK_ID_BITS-1:0] req_task;

  // queue state
  logic [NUM_LEVELS-1:0]   bitmap;
  logic [TOP_BITS-1:0]     top_lvl;
  logic [STATUS_BITS-1:0]  stat_reg;
  logic [IW-1:0]           head_idx [NUM_LEVELS];
  logic [CW-1:0]           lvl_cnt  [NUM_LEVELS];
  logic [TASK_ID_BITS-1:0] slot_mem [DEPTH];

  // response registers
  logic [TOP_BITS-1:0]     resp_top;
  logic [STATUS_BITS-1:0]  resp_stat;
  logic [TASK_ID_BITS-1:0] rd_data;

  // update step
  logic [LEVEL_BITS-1:0]   rd_lvl;
  logic [IW-1:0]           h;
  logic [CW-1:0]           c;
  logic                    full;
  logic                    empty;
  logic [SW-1:0]           sum;
  logic [IW-1:0]           tail_idx;
  logic [IW-1:0]           h_dec;
  logic [IW-1:0]           h_inc;
  logic                    ins_ok;
  logic                    del_ok;
  logic [IW-1:0]           h_new;
  logic [CW-1:0]           c_new;
  logic [IW-1:0]           wr_idx;
  logic [STATUS_BITS-1:0]  stat_next;
  logic [NUM_LEVELS-1:0]   bitmap_next;

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_mode  <= mode;
      req_level <= level;
      req_task  <= task_id;
    end
  end

  // one read port on the head table: request level, then top level
  assign rd_lvl = cmd.load ? top_lvl[LEVEL_BITS-1:0] : req_level;
  assign h      = head_idx[rd_lvl];
  assign c      = lvl_cnt[req_level];
  assign full   = (c == CNT_FULL);
  assign empty  = (c == '0);

  // ring arithmetic, tail position wraps at most once
  assign sum      = SW'(h) + SW'(c);
  assign tail_idx = (sum >= SUM_WRAP) ? IW'(sum - SUM_WRAP) : IW'(sum);
  assign h_dec    = (h == '0) ? IDX_LAST : h - IW'(1);
  assign h_inc    = (h == IDX_LAST) ? '0 : h + IW'(1);

  // decode the request
  always_comb begin
    ins_ok      = 1'b0;
    del_ok      = 1'b0;
    h_new       = h;
    c_new       = c;
    wr_idx      = tail_idx;
    stat_next   = STAT_OK;
    bitmap_next = bitmap;
    case (req_mode) inside
      MODE_TAIL, MODE_HEAD: begin
        if (full) begin
          stat_next = STAT_FULL;
        end else begin
          ins_ok = 1'b1;
          c_new  = c + CW'(1);
          bitmap_next[req_level] = 1'b1;
          if (req_mode == MODE_HEAD) begin
            h_new  = h_dec;
            wr_idx = h_dec;
          end
        end
      end
      MODE_DEL: begin
        if (empty) begin
          stat_next = STAT_EMPTY;
        end else begin
          del_ok = 1'b1;
          c_new  = c - CW'(1);
          h_new  = h_inc;
          if (c == CW'(1)) bitmap_next[req_level] = 1'b0;
        end
      end
      default: stat_next = STAT_OK;
    endcase
  end

  // queue state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bitmap  <= '0;
      top_lvl <= LEVEL_NONE;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_idx[i] <= '0;
        lvl_cnt[i]  <= '0;
      end
    end else if (cmd.exec) begin
      bitmap  <= bitmap_next;
      top_lvl <= first_ready(bitmap_next);
      if (ins_ok || del_ok) begin
        head_idx[req_level] <= h_new;
        lvl_cnt[req_level]  <= c_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) stat_reg <= stat_next;
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.exec && ins_ok) begin
      slot_mem[AW'({req_level, wr_idx})] <= req_task;
    end
    if (cmd.load) begin
      rd_data <= slot_mem[AW'({top_lvl[LEVEL_BITS-1:0], h})];
    end
  end

  // response registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      resp_top  <= top_lvl;
      resp_stat <= stat_reg;
    end
  end

  assign top_level = resp_top;
  assign status    = resp_stat;
  assign top_task  = (resp_top == LEVEL_NONE) ? '0 : rd_data;

endmodule

`default_nettype wire

[rtl/core/priority_bitmap_ready_queue_unit.sv]
// ----------------------------------------------------------------------------
// priority_bitmap_ready_queue_unit
// Scheduler ready queue: one ring FIFO of task ids per priority level.
// ----------------------------------------------------------------------------
// Request channel (in_valid/in_ready): mode, level, task_id. Mode inserts at
// the tail, inserts at the head (preempted task) or pops the head of a level.
// Response channel (out_valid/out_ready): top_level (16 when nothing ready),
// top_task (0 when nothing ready) and status (ok, full level, empty level).
// A request into a full level or a pop from an empty one leaves the queue
// unchanged and is flagged in status.
// A taken request is latched, applied in the update step, then read out in the
// read step, which registers the response. Requests are not overlapped: a new
// one is taken only after the FIFO read-modify-write with bitmap priority
// encode and the registered read of the slot memory at the new top level's head.
// A stalled response holds; the next request is still taken and processed,
// and its response waits in the read step until the held one is taken.
// Reset clears bitmap, counts and head indexes; the slot memory is not
// cleared and needs no sweep, since only written slots reach the output.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_bitmap_ready_queue_unit
  import pbrq_pkg::*;
#(
  parameter int SLOTS_PER_LEVEL = DEF_SLOTS_PER_LEVEL
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [MODE_BITS-1:0]     mode,
  input  wire logic [LEVEL_BITS-1:0]    level,
  input  wire logic [TASK_ID_BITS-1:0]  task_id,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic      [TOP_BITS-1:0]      top_level,
  output logic      [TASK_ID_BITS-1:0]  top_task,
  output logic      [STATUS_BITS-1:0]   status
);

  pbrq_cmd_t cmd;

  pbrq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  pbrq_dpath #(
    .SLOTS_PER_LEVEL (SLOTS_PER_LEVEL)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .mode      (mode),
    .level     (level),
    .task_id   (task_id),
    .top_level (top_level),
    .top_task  (top_task),
    .status    (status)
  );

endmodule

`default_nettype wire

[rtl/core/pbrq_checker.sv]
// ----------------------------------------------------------------------------
// pbrq_checker
// Port-level checks on the ready queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pbrq_checker
  import pbrq_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [TOP_BITS-1:0]     top_level,
  input wire logic [TASK_ID_BITS-1:0] top_task,
  input wire logic [STATUS_BITS-1:0]  status
);

  // stalled response holds its payload
  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(top_level) &&
      $stable(top_task) && $stable(status))
    else $error("response changed while stalled");

  // reported top level is a real level or the none marker
  a_top_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> top_level <= LEVEL_NONE)
    else $error("top level out of range");

  // empty queue reports task zero
  a_none_task: assert property (@(posedge clk) disable iff (rst)
    out_valid && top_level == LEVEL_NONE |-> top_task == '0)
    else $error("task reported with nothing ready");

  // status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == STAT_OK || status == STAT_FULL || status == STAT_EMPTY)
    else $error("undefined status code");

  // a request is never followed by another in the next cycle
  a_req_spacing: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken back to back");

endmodule

bind priority_bitmap_ready_queue_unit pbrq_checker u_pbrq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .top_level (top_level),
  .top_task  (top_task),
  .status    (status)
);

`default_nettype wire
